[src/vhsf_pkg.sv]
// ----------------------------------------------------------------------------
// vhsf_pkg
// Shared types and register indexes for the vertical half-line shift filter.
// ----------------------------------------------------------------------------
`default_nettype none

package vhsf_pkg;

  // Configuration register indexes.
  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_LINE_WIDTH = 2'd0;
  localparam reg_index_t REG_LINE_COUNT = 2'd1;
  localparam reg_index_t REG_KEEP_TOP   = 2'd2;

  typedef logic [11:0] cfg_data_t;
  typedef logic [7:0]  pixel_t;
  typedef logic [10:0] coord_t;

  // Per-item bookkeeping held while the line store read completes and the
  // results of the item are sent out.
  typedef struct packed {
    pixel_t     pixel;
    logic [1:0] slot;     // line store slot of the current row
    logic       first;    // kept first row (keep_top = 1, row 0)
    logic       row_two;  // first new line: two-line average
    logic [1:0] count;    // number of results of this item
    coord_t     col;
    coord_t     mid_row;  // destination of new line r-2
    coord_t     end_row;  // destination of new line h-2
    coord_t     keep_row; // destination of the kept last row
  } stage_t;

endpackage

`default_nettype wire

[src/vhsf_ram.sv]
// ----------------------------------------------------------------------------
// vhsf_ram
// Single-port-write, single-port-read RAM with a registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module vhsf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the entry written in the same cycle returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/vertical_halfpel_shift_filter.sv]
// ----------------------------------------------------------------------------
// vertical_halfpel_shift_filter
// Moves an 8-bit field down half a line: 4-tap filter, 2-tap at the edges.
// ----------------------------------------------------------------------------
// Usage: pixels of a field enter in raster order on the pix channel; the
// first pixel of a field carries frame_start. Each item is accepted at a
// clock edge with pix_valid high and pix_stall low. Results leave on the res
// channel under the same rule with res_valid and res_stall; every result
// carries its destination row and column, and last_of_run marks the last
// result caused by one input pixel. Row 1 causes no result at all.
// Configuration registers (line_width, line_count, keep_top) are written
// through the cfg channel, which is always ready; the user must write them
// only while the block is idle, as the block itself does not enforce this.
// Each result is registered in the output register after the item stage.
// Throughput is one pixel per cycle while res_stall is low, on every row
// but the last one, which emits two or three results per pixel through the
// single result output register and holds pix_stall high until all are out.
// Three line stores (one per row modulo 3) are read at the current column
// in the cycle a pixel is accepted, and the pixel is written to its own slot
// in the same cycle, so no forwarding is needed.
// Reset clears the counters and the pipeline; the line stores are not
// cleared. When res_stall is high the finished result holds, the pending item
// waits behind it, and pix_stall rises only once that item cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module vertical_halfpel_shift_filter
  import vhsf_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // pixel channel
  input  wire logic       pix_valid,
  output logic            pix_stall,
  input  wire pixel_t     pixel,
  input  wire logic       frame_start,
  // result channel
  output logic            res_valid,
  input  wire logic       res_stall,
  output pixel_t          value,
  output coord_t          dest_row,
  output coord_t          dest_col,
  output logic            last_of_run,
  // configuration channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire reg_index_t cfg_index,
  input  wire cfg_data_t  cfg_data
);

  localparam int CW  = $clog2(MAX_WIDTH);       // column index bits
  localparam int WW  = $clog2(MAX_WIDTH + 1);   // bits of a line width
  localparam int RW  = $clog2(MAX_HEIGHT);      // row index bits
  localparam int HW  = $clog2(MAX_HEIGHT + 1);  // bits of a line count
  localparam int W_RST = (720 > MAX_WIDTH) ? MAX_WIDTH : 720;
  localparam int H_RST = (576 > MAX_HEIGHT) ? MAX_HEIGHT : 576;
  localparam int HL_SLOT_RST = (H_RST - 1) % 3;

  // Remainder modulo 3 by summing base-4 digits (4 is 1 modulo 3).
  function automatic logic [1:0] mod3(input logic [15:0] x);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(x[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) u = t - 3'd6;
    else if (t >= 3'd3) u = t - 3'd3;
    else u = t;
    return u[1:0];
  endfunction

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic pixel_t avg2(input pixel_t a, input pixel_t b);
    logic [8:0] s;
    s = 9'(a) + 9'(b);
    return s[8:1];
  endfunction

  // (5*(inner0+inner1) - (outer0+outer1)) >> 3, clipped to 0..255.
  function automatic pixel_t tap4(input pixel_t o0, input pixel_t i0,
                                  input pixel_t i1, input pixel_t o1);
    logic [8:0]         inner;
    logic [8:0]         outer;
    logic signed [12:0] s;
    inner = 9'(i0) + 9'(i1);
    outer = 9'(o0) + 9'(o1);
    s = $signed({2'b00, inner, 2'b00}) + $signed({4'b0000, inner})
        - $signed({4'b0000, outer});
    if (s < 0) return 8'd0;
    else if (s[12:3] > 10'd255) return 8'd255;
    else return s[10:3];
  endfunction

  // --------------------------------------------------------------------------
  // Configuration, stored already clamped to the legal geometry.
  // --------------------------------------------------------------------------
  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic          keep_top;
  logic [1:0]    last_slot;     // (height_eff - 1) mod 3
  logic [WW-1:0] width_next;
  logic [HW-1:0] height_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data == '0) width_next = WW'(1);
    else if (cfg_data > MAX_WIDTH) width_next = WW'(MAX_WIDTH);
    else width_next = WW'(cfg_data);
    if (cfg_data < 12'd3) height_next = HW'(3);
    else if (cfg_data > MAX_HEIGHT) height_next = HW'(MAX_HEIGHT);
    else height_next = HW'(cfg_data);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(W_RST);
      height_eff <= HW'(H_RST);
      keep_top   <= 1'b0;
      last_slot  <= 2'(HL_SLOT_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_WIDTH: width_eff <= width_next;
        REG_LINE_COUNT: begin
          height_eff <= height_next;
          last_slot  <= mod3(16'(height_next - HW'(1)));
        end
        REG_KEEP_TOP:   keep_top <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Position counters and the line store.
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_cnt;
  logic [RW-1:0] row_cnt;
  logic [1:0]    slot;
  logic [CW-1:0] col_cnt_next;
  logic [RW-1:0] row_cnt_next;
  logic [1:0]    slot_next;

  logic [CW-1:0] col_cur;
  logic [RW-1:0] row_cur;
  logic [1:0]    slot_cur;
  logic          col_end;
  logic          row_end;
  logic          accept;

  always_comb begin
    if (frame_start) begin
      col_cur  = '0;
      row_cur  = '0;
      slot_cur = 2'd0;
    end else begin
      col_cur  = (WW'(col_cnt) >= width_eff) ? CW'(width_eff - WW'(1)) : col_cnt;
      if (HW'(row_cnt) >= height_eff) begin
        row_cur  = RW'(height_eff - HW'(1));
        slot_cur = last_slot;
      end else begin
        row_cur  = row_cnt;
        slot_cur = slot;
      end
    end
    col_end = (WW'(col_cur) == width_eff - WW'(1));
    row_end = (HW'(row_cur) == height_eff - HW'(1));
    col_cnt_next = col_cur + CW'(1);
    row_cnt_next = row_cur;
    slot_next    = slot_cur;
    if (col_end) begin
      col_cnt_next = '0;
      if (row_end) begin
        row_cnt_next = '0;
        slot_next    = 2'd0;
      end else begin
        row_cnt_next = row_cur + RW'(1);
        slot_next    = slot_inc(slot_cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      slot    <= 2'd0;
    end else if (accept) begin
      col_cnt <= col_cnt_next;
      row_cnt <= row_cnt_next;
      slot    <= slot_next;
    end
  end

  // One store per row modulo 3; all three are read at the current column.
  pixel_t rd_data [3];

  for (genvar i = 0; i < 3; i++) begin : g_line
    vhsf_ram #(
      .WIDTH(8),
      .DEPTH(MAX_WIDTH)
    ) u_ram (
      .clk  (clk),
      .we   (accept && (slot_cur == 2'(i))),
      .waddr(col_cur),
      .wdata(pixel),
      .re   (accept),
      .raddr(col_cur),
      .rdata(rd_data[i])
    );
  end

  // --------------------------------------------------------------------------
  // Item stage: waits for the store read, then hands out its results one
  // per cycle to the output register whenever that register is not stalled.
  // --------------------------------------------------------------------------
  stage_t        st;
  stage_t        st_next;
  logic          st_valid;
  logic [1:0]    st_idx;
  logic          emit;
  logic          st_done;
  logic          out_load;
  logic [HW-1:0] mid_row_w;
  logic [HW-1:0] end_row_w;
  logic [HW-1:0] keep_row_w;
  logic          is_first;
  logic          is_mid;

  assign out_load = !res_valid || !res_stall;
  assign emit     = st_valid && (st.count != 2'd0) && out_load;
  assign st_done  = st_valid && ((st.count == 2'd0) || (emit && (st_idx == st.count - 2'd1)));
  assign pix_stall = st_valid && !st_done;
  assign accept    = pix_valid && !pix_stall;

  always_comb begin
    mid_row_w  = HW'(row_cur) - HW'(2) + HW'(keep_top);
    end_row_w  = height_eff - HW'(2) + HW'(keep_top);
    keep_row_w = height_eff - HW'(1);
    is_first   = (row_cur == '0) && keep_top;
    is_mid     = (HW'(row_cur) >= HW'(2));
    st_next.pixel    = pixel;
    st_next.slot     = slot_cur;
    st_next.first    = is_first;
    st_next.row_two  = (HW'(row_cur) == HW'(2));
    st_next.col      = 11'(col_cur);
    st_next.mid_row  = 11'(mid_row_w);
    st_next.end_row  = 11'(end_row_w);
    st_next.keep_row = 11'(keep_row_w);
    if (is_first) st_next.count = 2'd1;
    else if (row_end) st_next.count = keep_top ? 2'd2 : 2'd3;
    else if (is_mid) st_next.count = 2'd1;
    else st_next.count = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
      st_idx   <= 2'd0;
    end else if (accept) begin
      st_valid <= 1'b1;
      st_idx   <= 2'd0;
    end else begin
      if (st_done) begin
        st_valid <= 1'b0;
      end
      if (emit) begin
        st_idx <= st_idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st <= st_next;
    end
  end

  // Rows r-1, r-2 and r-3 as seen from the item's own slot.
  pixel_t m1;
  pixel_t m2;
  pixel_t m3;
  pixel_t res_value;
  coord_t res_row;

  always_comb begin
    case (st.slot)
      2'd0: begin
        m3 = rd_data[0];
        m2 = rd_data[1];
        m1 = rd_data[2];
      end
      2'd1: begin
        m3 = rd_data[1];
        m2 = rd_data[2];
        m1 = rd_data[0];
      end
      default: begin
        m3 = rd_data[2];
        m2 = rd_data[0];
        m1 = rd_data[1];
      end
    endcase
    if (st.first) begin
      res_value = st.pixel;
      res_row   = '0;
    end else begin
      case (st_idx)
        2'd0: begin
          res_value = st.row_two ? avg2(m2, m1) : tap4(m3, m2, m1, st.pixel);
          res_row   = st.mid_row;
        end
        2'd1: begin
          res_value = avg2(m1, st.pixel);
          res_row   = st.end_row;
        end
        default: begin
          res_value = st.pixel;
          res_row   = st.keep_row;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value       <= res_value;
      dest_row    <= res_row;
      dest_col    <= st.col;
      last_of_run <= (st_idx == st.count - 2'd1);
    end
  end

endmodule

`default_nettype wire

[src/vhsf_checker.sv]
// ----------------------------------------------------------------------------
// vhsf_checker
// Port-level checks of the vertical half-line shift filter, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module vhsf_checker
  import vhsf_pkg::*;
(
  input wire logic   clk,
  input wire logic   rst,
  input wire logic   res_valid,
  input wire logic   res_stall,
  input wire pixel_t value,
  input wire coord_t dest_row,
  input wire coord_t dest_col,
  input wire logic   last_of_run
);

  // No result is shown right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(value) && $stable(dest_row)
                               && $stable(dest_col) && $stable(last_of_run))
    else $error("stalled result changed");

  // The results of one pixel follow each other without a gap.
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !last_of_run |=> res_valid)
    else $error("gap inside a run of results");

  // All results of one pixel share its column.
  a_run_column: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !last_of_run |=> $stable(dest_col))
    else $error("column changed inside a run of results");

  // Within a run the destination row changes from one result to the next.
  a_run_rows: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_stall && !last_of_run |=> dest_row != $past(dest_row))
    else $error("repeated destination row inside a run");

endmodule

bind vertical_halfpel_shift_filter vhsf_checker u_vhsf_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .value      (value),
  .dest_row   (dest_row),
  .dest_col   (dest_col),
  .last_of_run(last_of_run)
);

`default_nettype wire
